/* rtl/gru_pkg.sv */
`timescale 1ns / 1ps

package gru_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_CODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPRESSED   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT = 3'd3;

    // pixel depth codes
    localparam logic [1:0] DEPTH_1BPP = 2'd0;
    localparam logic [1:0] DEPTH_2BPP = 2'd1;
    localparam logic [1:0] DEPTH_4BPP = 2'd2;
    localparam logic [1:0] DEPTH_8BPP = 2'd3;

    // width of the repeat field in front of each run value
    localparam logic [4:0] REPEAT_BITS = 5'd4;

    // bit accumulator: 16 buffered bits plus one byte
    localparam int ACC_W = 24;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // input transfer: merge byte into the accumulator
        logic fetch;      // take the next value or run element from the accumulator
        logic emit;       // write one pixel into the output register
        logic last;       // pixel being emitted closes the byte
        logic dec_rep;    // one more pixel of the current run
        logic writeback;  // byte exhausted, keep leftover bits
        logic stop;       // bitmap full, drop buffered bits
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic skip;       // byte ignored (finished or empty bitmap)
        logic avail;      // another value or element can be taken
        logic more;       // current run has pixels left after this one
        logic slot_free;  // output register can take a pixel
        logic pre_done;   // position already beyond the bitmap
        logic post_done;  // this pixel completes the bitmap
    } t_status;

    function automatic logic [4:0] f_bpp(input logic [1:0] depth);
        logic [4:0] bits;
        case (depth)
            DEPTH_1BPP: bits = 5'd1;
            DEPTH_2BPP: bits = 5'd2;
            DEPTH_4BPP: bits = 5'd4;
            default:    bits = 5'd8;
        endcase
        return bits;
    endfunction

    function automatic logic [7:0] f_vmask(input logic [1:0] depth);
        logic [7:0] mask;
        case (depth)
            DEPTH_1BPP: mask = 8'h01;
            DEPTH_2BPP: mask = 8'h03;
            DEPTH_4BPP: mask = 8'h0F;
            default:    mask = 8'hFF;
        endcase
        return mask;
    endfunction

    // value to coverage strength
    function automatic logic [7:0] f_scale(input logic [1:0] depth, input logic [7:0] v);
        logic [7:0] s;
        case (depth)
            DEPTH_1BPP: s = (v != 8'd0) ? 8'hFF : 8'h00;
            DEPTH_2BPP: s = 8'(v * 8'd85);
            DEPTH_4BPP: s = 8'(v * 8'd17);
            default:    s = v;
        endcase
        return s;
    endfunction

endpackage

/* rtl/gru_if.sv */
`timescale 1ns / 1ps

// byte stream into the unpacker
interface gru_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_glyph;

    modport source (output valid, output data_byte, output first_of_glyph, input ready);
    modport sink   (input valid, input data_byte, input first_of_glyph, output ready);
endinterface

// pixel stream out of the unpacker
interface gru_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_row;
    logic [7:0] pixel_column;
    logic [7:0] strength;
    logic       last_of_item;
    logic       glyph_done;

    modport source (output valid, output pixel_row, output pixel_column, output strength,
                    output last_of_item, output glyph_done, input ready);
    modport sink   (input valid, input pixel_row, input pixel_column, input strength,
                    input last_of_item, input glyph_done, output ready);
endinterface

// register write channel
interface gru_cfg_if
    import gru_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/glyph_rle_bitmap_unpacker.sv */
`timescale 1ns / 1ps

// Glyph bitmap unpacker: packed or run-length coded glyph bytes in, pixels out.
// i_in takes one bitmap byte per transfer; first_of_glyph restarts the scan
// position and the bit buffer before that byte is used. o_out gives one pixel
// per transfer as flipped row, column and 8-bit strength, with last_of_item on
// the final pixel of a byte and glyph_done on the pixel that fills the bitmap.
// i_cfg writes depth, mode, width and height; it is always ready. It is to be
// used only between bytes; the user is bound to this, the block does not enforce it.
// Steps: a byte is taken while the sequencer is idle, its first value or run
// element is fetched in the next cycle, then the pixel sequencer gives one pixel
// per cycle while the output register is free. Bytes that give no pixel end
// early: an ignored byte at its transfer, a byte with no whole element buffered
// in the fetch state, and a byte whose position lies past the bitmap in the emit state.
// Input is taken only while the sequencer is idle; the last pixel of a byte may
// still sit in the output register when the next byte is taken.
// A stalled receiver holds the output register and the sequencer waits on it.
// Reset clears the scan state, sets the registers to 1 bpp raw, 8 x 8, and
// empties the output register.
module glyph_rle_bitmap_unpacker
    import gru_pkg::*;
#(
    parameter int COORD_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gru_in_if.sink    i_in,
    gru_out_if.source o_out,
    gru_cfg_if.sink   i_cfg
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // sequencer
    gru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // bit buffer, scan position and output register
    gru_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_write      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_data_byte      (i_in.data_byte),
        .i_first_of_glyph (i_in.first_of_glyph),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_pixel_row      (o_out.pixel_row),
        .o_pixel_column   (o_out.pixel_column),
        .o_strength       (o_out.strength),
        .o_last_of_item   (o_out.last_of_item),
        .o_glyph_done     (o_out.glyph_done)
    );

endmodule

/* rtl/gru_ctrl.sv */
`timescale 1ns / 1ps

module gru_ctrl
    import gru_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;

    assign o_in_ready = r_in_ready;

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    if (!i_status.skip) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                if (i_status.avail) begin
                    o_cmd.fetch = 1'b1;
                    n_state     = S_EMIT;
                end else begin
                    o_cmd.writeback = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_status.pre_done) begin
                    o_cmd.stop = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.post_done) begin
                        o_cmd.stop = 1'b1;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end else if (i_status.more) begin
                        o_cmd.dec_rep = 1'b1;
                    end else if (i_status.avail) begin
                        o_cmd.fetch = 1'b1;
                    end else begin
                        o_cmd.last      = 1'b1;
                        o_cmd.writeback = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    // ready only while idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");

    // a pixel is emitted only from the emit state
    a_emit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == S_EMIT))
        else $error("pixel emitted outside emit state");

    // a skipped byte leaves the controller idle
    a_skip_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_status.skip) |=> (r_state == S_IDLE))
        else $error("skipped byte started work");

endmodule

/* rtl/gru_datapath.sv */
`timescale 1ns / 1ps

module gru_datapath
    import gru_pkg::*;
#(
    parameter int COORD_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // register writes
    input  logic                   i_cfg_write,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input byte
    input  logic [7:0]             i_data_byte,
    input  logic                   i_first_of_glyph,
    // control
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    // pixel output
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [7:0]             o_pixel_row,
    output logic [7:0]             o_pixel_column,
    output logic [7:0]             o_strength,
    output logic                   o_last_of_item,
    output logic                   o_glyph_done
);

    localparam int XW = (COORD_BITS > 8) ? COORD_BITS : 8;

    // configuration
    logic [1:0] r_depth_code;
    logic       r_compressed;
    logic [7:0] r_glyph_width;
    logic [7:0] r_glyph_height;

    // bit stream and scan state
    logic [ACC_W-1:0]      r_acc;
    logic [4:0]            r_nbits;
    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic                  r_finished;
    logic [1:0]            r_elems;
    logic [3:0]            r_reps;
    logic [7:0]            r_value;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_row;
    logic [7:0] r_out_col;
    logic [7:0] r_out_strength;
    logic       r_out_last;
    logic       r_out_done;

    logic [4:0]             bpp, esize, vshift;
    logic [7:0]             vmask;
    logic [15:0]            base_acc;
    logic [4:0]             base_n, shamt, n_nbits_ld;
    logic [ACC_W-1:0]       n_acc_ld;
    logic                   eff_finished;
    logic [XW-1:0]          w_x, h_x;
    logic                   wrap_pre, wrap_post;
    logic [COORD_BITS-1:0]  col_pre, row_pre, col_inc, col_post, row_post;
    logic [XW-1:0]          col_pre_x, row_pre_x;
    logic [7:0]             n_pix_row;
    logic [7:0]             raw_value;

    // element geometry for the current depth
    assign bpp    = f_bpp(r_depth_code);
    assign vmask  = f_vmask(r_depth_code);
    assign esize  = bpp + REPEAT_BITS;
    assign vshift = r_compressed ? esize : bpp;

    // byte merge at the input transfer
    assign base_acc     = i_first_of_glyph ? 16'd0 : r_acc[15:0];
    assign base_n       = i_first_of_glyph ? 5'd0 : r_nbits;
    assign shamt        = (base_n > 5'd16) ? 5'd16 : base_n;
    assign n_acc_ld     = {8'd0, base_acc} | (ACC_W'(i_data_byte) << shamt);
    assign n_nbits_ld   = shamt + 5'd8;
    assign eff_finished = i_first_of_glyph ? 1'b0 : r_finished;

    // position before and after the pixel
    assign w_x       = XW'(r_glyph_width);
    assign h_x       = XW'(r_glyph_height);
    assign wrap_pre  = XW'(r_col) >= w_x;
    assign col_pre   = wrap_pre ? '0 : r_col;
    assign row_pre   = wrap_pre ? COORD_BITS'(r_row + 1'b1) : r_row;
    assign col_pre_x = XW'(col_pre);
    assign row_pre_x = XW'(row_pre);
    assign col_inc   = COORD_BITS'(col_pre + 1'b1);
    assign wrap_post = XW'(col_inc) >= w_x;
    assign col_post  = wrap_post ? '0 : col_inc;
    assign row_post  = wrap_post ? COORD_BITS'(row_pre + 1'b1) : row_pre;
    assign n_pix_row = r_glyph_height - 8'd1 - row_pre_x[7:0];

    // value field of the next element
    assign raw_value = (r_compressed ? r_acc[11:4] : r_acc[7:0]) & vmask;

    // status to the controller
    always_comb begin
        o_status.skip      = eff_finished || (r_glyph_width == 8'd0) ||
                             (r_glyph_height == 8'd0);
        o_status.avail     = r_compressed ? ((r_elems < 2'd2) && (r_nbits >= esize))
                                          : (r_nbits >= bpp);
        o_status.more      = (r_reps != 4'd0);
        o_status.slot_free = !r_out_valid || i_out_ready;
        o_status.pre_done  = row_pre_x >= h_x;
        o_status.post_done = XW'(row_post) >= h_x;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_code   <= DEPTH_1BPP;
            r_compressed   <= 1'b0;
            r_glyph_width  <= 8'd8;
            r_glyph_height <= 8'd8;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                REG_DEPTH_CODE:   r_depth_code   <= i_cfg_data[1:0];
                REG_COMPRESSED:   r_compressed   <= i_cfg_data[0];
                REG_GLYPH_WIDTH:  r_glyph_width  <= i_cfg_data;
                REG_GLYPH_HEIGHT: r_glyph_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // bit accumulator, run state and scan position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_nbits    <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_finished <= 1'b0;
            r_elems    <= '0;
            r_reps     <= '0;
        end else begin
            if (i_cmd.load) begin
                if (i_first_of_glyph) begin
                    r_col      <= '0;
                    r_row      <= '0;
                    r_finished <= 1'b0;
                end
                if (!o_status.skip) begin
                    r_acc   <= n_acc_ld;
                    r_nbits <= n_nbits_ld;
                    r_elems <= '0;
                end else if (i_first_of_glyph) begin
                    r_acc   <= '0;
                    r_nbits <= '0;
                end
            end

            if (i_cmd.emit) begin
                r_col <= col_post;
                r_row <= row_post;
            end else if (i_cmd.stop) begin
                r_col <= col_pre;
                r_row <= row_pre;
            end

            if (i_cmd.stop) begin
                r_finished <= 1'b1;
                r_acc      <= '0;
                r_nbits    <= '0;
            end else if (i_cmd.fetch) begin
                r_acc   <= r_acc >> vshift;
                r_nbits <= r_nbits - vshift;
                r_reps  <= r_compressed ? r_acc[3:0] : 4'd0;
                if (r_compressed) begin
                    r_elems <= r_elems + 2'd1;
                end
            end else if (i_cmd.writeback) begin
                r_acc <= {8'd0, r_acc[15:0]};
            end

            if (i_cmd.dec_rep) begin
                r_reps <= r_reps - 4'd1;
            end
        end
    end

    // strength of the current value
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_value <= f_scale(r_depth_code, raw_value);
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_row      <= n_pix_row;
            r_out_col      <= col_pre_x[7:0];
            r_out_strength <= r_value;
            r_out_last     <= i_cmd.last;
            r_out_done     <= o_status.post_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_row    = r_out_row;
    assign o_pixel_column = r_out_col;
    assign o_strength     = r_out_strength;
    assign o_last_of_item = r_out_last;
    assign o_glyph_done   = r_out_done;

    // no pixel overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_status.slot_free)
        else $error("pixel overwrote a pending transfer");

    // a fetch only takes a complete element
    a_fetch_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fetch |-> o_status.avail)
        else $error("fetch without a complete element");

    // a finished bitmap holds no buffered bits
    a_finished_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_nbits == 5'd0))
        else $error("bits buffered after bitmap finished");

    // the completing pixel always closes its byte
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_last)
        else $error("glyph done without last of item");

    // accumulator never holds more than sixteen bits plus a byte
    a_nbits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nbits <= 5'd24)
        else $error("bit count out of range");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import gru_pkg::*;

    localparam int RANDOM_ITEMS = 170;
    localparam int MAX_GAP      = 6;
    localparam int SETTLE_TAIL  = 8;
    localparam int GLYPH_CAP    = 48;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] strength;
        logic       last;
        logic       done;
    } t_pixel;

    typedef enum {ROW_REG, ROW_BYTE} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [7:0]             value;
        bit                     first;
        bit                     fixed;
        int                     fixed_count;
        t_pixel                 fixed_px;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;

    gru_in_if  in_bus ();
    gru_out_if px_bus ();
    gru_cfg_if reg_bus ();

    glyph_rle_bitmap_unpacker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (px_bus),
        .i_cfg   (reg_bus)
    );

    // unpacker shadow: registers and scan state
    logic [1:0]  depth_r;
    bit          rle_r;
    logic [7:0]  width_r;
    logic [7:0]  height_r;
    logic [15:0] buf_bits;
    logic [4:0]  buf_count;
    logic [7:0]  col_pos;
    logic [7:0]  row_pos;
    bit          glyph_full;

    t_pixel byte_px[$];
    t_pixel pixels_due[$];

    // fixed expectation for the directed rows that carry one
    bit     fixed_on;
    int     fixed_count;
    t_pixel fixed_px;

    t_plan_row plan[$];
    int        mismatches;
    int        quiet_cycles;
    bit        no_idle;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] coverage_of(input logic [7:0] v);
        logic [7:0] s;
        case (depth_r)
            DEPTH_1BPP: s = (v != 8'd0) ? 8'hFF : 8'h00;
            DEPTH_2BPP: s = v * 8'd85;
            DEPTH_4BPP: s = v * 8'd17;
            default:    s = v;
        endcase
        return s;
    endfunction

    // one pixel at the scan position; 0 once the bitmap is full
    function automatic bit place_pixel(input logic [7:0] s);
        t_pixel p;
        if (col_pos >= width_r) begin
            col_pos = 8'd0;
            row_pos = row_pos + 8'd1;
        end
        if (row_pos >= height_r) begin
            glyph_full = 1'b1;
            return 1'b0;
        end
        p.row      = height_r - 8'd1 - row_pos;
        p.col      = col_pos;
        p.strength = s;
        p.last     = 1'b0;
        p.done     = 1'b0;
        col_pos    = col_pos + 8'd1;
        if (col_pos >= width_r) begin
            col_pos = 8'd0;
            row_pos = row_pos + 8'd1;
        end
        if (row_pos >= height_r) begin
            glyph_full = 1'b1;
            p.done     = 1'b1;
            byte_px.push_back(p);
            return 1'b0;
        end
        byte_px.push_back(p);
        return 1'b1;
    endfunction

    // pixels that one byte gives, left in byte_px
    function automatic void unpack_byte(input logic [7:0] data, input bit first);
        int          bpp;
        int          nb;
        int          esize;
        int          elems;
        int          reps;
        logic [23:0] acc;
        logic [7:0]  vmask;
        logic [7:0]  s;
        bit          going;
        t_pixel      p;
        byte_px.delete();
        going = 1'b1;
        if (first) begin
            buf_bits   = 16'd0;
            buf_count  = 5'd0;
            col_pos    = 8'd0;
            row_pos    = 8'd0;
            glyph_full = 1'b0;
        end
        if (glyph_full || width_r == 8'd0 || height_r == 8'd0) return;
        bpp   = 1 << depth_r;
        vmask = 8'((1 << bpp) - 1);
        nb    = (buf_count > 5'd16) ? 16 : int'(buf_count);
        acc   = {8'h00, buf_bits} | (24'(data) << nb);
        nb    = nb + 8;
        if (rle_r) begin
            esize = 4 + bpp;
            elems = 0;
            while (going && elems < 2 && nb >= esize) begin
                reps  = int'(acc[3:0]) + 1;
                s     = coverage_of(8'(acc >> 4) & vmask);
                acc   = acc >> esize;
                nb    = nb - esize;
                elems = elems + 1;
                for (int k = 0; going && k < reps; k++) going = place_pixel(s);
            end
        end else begin
            while (going && nb >= bpp) begin
                s     = coverage_of(acc[7:0] & vmask);
                acc   = acc >> bpp;
                nb    = nb - bpp;
                going = place_pixel(s);
            end
        end
        if (glyph_full) begin
            buf_bits  = 16'd0;
            buf_count = 5'd0;
        end else begin
            buf_bits  = acc[15:0];
            buf_count = 5'(nb);
        end
        if (byte_px.size() > 0) begin
            p      = byte_px.pop_back();
            p.last = 1'b1;
            byte_px.push_back(p);
        end
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_DEPTH_CODE:   depth_r  = val[1:0];
            REG_COMPRESSED:   rle_r    = val[0];
            REG_GLYPH_WIDTH:  width_r  = val;
            REG_GLYPH_HEIGHT: height_r = val;
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches = mismatches + 1;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // shadow update on every transfer, and pixel check
    always @(posedge i_clk) begin : monitor
        t_pixel got;
        t_pixel want;
        if (!i_rst_n) begin
            depth_r    = DEPTH_1BPP;
            rle_r      = 1'b0;
            width_r    = 8'd8;
            height_r   = 8'd8;
            buf_bits   = 16'd0;
            buf_count  = 5'd0;
            col_pos    = 8'd0;
            row_pos    = 8'd0;
            glyph_full = 1'b0;
            pixels_due.delete();
        end else begin
            if (reg_bus.valid && reg_bus.ready) apply_reg(reg_bus.index, reg_bus.data);
            if (in_bus.valid && in_bus.ready) begin
                unpack_byte(in_bus.data_byte, in_bus.first_of_glyph);
                if (fixed_on) begin
                    if (fixed_count > 0) pixels_due.push_back(fixed_px);
                end else begin
                    foreach (byte_px[i]) pixels_due.push_back(byte_px[i]);
                end
            end
            if (px_bus.valid && px_bus.ready) begin
                got = {px_bus.pixel_row, px_bus.pixel_column, px_bus.strength,
                       px_bus.last_of_item, px_bus.glyph_done};
                if (pixels_due.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t ns: pixel transfer, expected none, got row %0d col %0d str %0d",
                             $time, got.row, got.col, got.strength);
                end else begin
                    want = pixels_due.pop_front();
                    check_field("pixel_row", want.row, got.row);
                    check_field("pixel_column", want.col, got.col);
                    check_field("strength", want.strength, got.strength);
                    check_field("last_of_item", want.last, got.last);
                    check_field("glyph_done", want.done, got.done);
                end
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (px_bus.valid && px_bus.ready) ||
            (reg_bus.valid && reg_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // pixel receiver with random stalls
    initial begin
        int gap;
        px_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
            if (gap > 0) begin
                px_bus.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            px_bus.ready = 1'b1;
            do @(posedge i_clk); while (!px_bus.valid);
            @(negedge i_clk);
        end
    end

    // one byte transfer; valid stays high for a back-to-back successor
    task automatic send_byte(input logic [7:0] data, input bit first);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
        if (gap > 0) begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.data_byte      = data;
        in_bus.first_of_glyph = first;
        in_bus.valid          = 1'b1;
        do @(posedge i_clk); while (!in_bus.ready);
        @(negedge i_clk);
    endtask

    // hold input until every pixel is out and the block has gone quiet
    task automatic settle();
        in_bus.valid = 1'b0;
        while (pixels_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_TAIL) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        in_bus.valid  = 1'b0;
        reg_bus.index = idx;
        reg_bus.data  = val;
        reg_bus.valid = 1'b1;
        do @(posedge i_clk); while (!reg_bus.ready);
        @(negedge i_clk);
        reg_bus.valid = 1'b0;
    endtask

    // empty table row
    function automatic t_plan_row blank_row();
        t_plan_row r;
        r.kind        = ROW_BYTE;
        r.index       = '0;
        r.value       = 8'd0;
        r.first       = 1'b0;
        r.fixed       = 1'b0;
        r.fixed_count = 0;
        r.fixed_px    = '0;
        return r;
    endfunction

    function automatic void add_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        t_plan_row r;
        r       = blank_row();
        r.kind  = ROW_REG;
        r.index = idx;
        r.value = val;
        plan.push_back(r);
    endfunction

    function automatic void add_byte(input logic [7:0] val, input bit first);
        t_plan_row r;
        r       = blank_row();
        r.kind  = ROW_BYTE;
        r.value = val;
        r.first = first;
        plan.push_back(r);
    endfunction

    // byte whose result is written out by hand: none, or a single pixel
    function automatic void add_fixed(input logic [7:0] val, input bit first, input int cnt,
                                      input logic [7:0] row, input logic [7:0] col,
                                      input logic [7:0] str, input bit done);
        t_plan_row r;
        r             = blank_row();
        r.kind        = ROW_BYTE;
        r.value       = val;
        r.first       = first;
        r.fixed       = 1'b1;
        r.fixed_count = cnt;
        r.fixed_px    = {row, col, str, 1'b1, done};
        plan.push_back(r);
    endfunction

    initial begin
        int         total;
        int         phase;
        int         target;
        int         in_phase;
        int         glyph_bytes;
        int         pick;
        bit         first_next;
        bit         counted;
        logic [7:0] w;
        logic [7:0] h;

        mismatches            = 0;
        no_idle               = 1'b0;
        fixed_on              = 1'b0;
        fixed_count           = 0;
        fixed_px              = '0;
        i_rst_n               = 1'b0;
        in_bus.valid          = 1'b0;
        in_bus.data_byte      = 8'd0;
        in_bus.first_of_glyph = 1'b0;
        reg_bus.valid         = 1'b0;
        reg_bus.index         = '0;
        reg_bus.data          = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part: defaults after reset
        add_byte(8'hA5, 1'b1);
        add_byte(8'h5A, 1'b0);
        // one-pixel bitmap at 8 bpp, then bytes on a full bitmap are dropped
        add_reg(REG_DEPTH_CODE, DEPTH_8BPP);
        add_reg(REG_GLYPH_WIDTH, 8'd1);
        add_reg(REG_GLYPH_HEIGHT, 8'd1);
        add_fixed(8'hFF, 1'b1, 1, 8'd0, 8'd0, 8'd255, 1'b1);
        add_fixed(8'h12, 1'b0, 0, 8'd0, 8'd0, 8'd0, 1'b0);
        add_fixed(8'h00, 1'b1, 1, 8'd0, 8'd0, 8'd0, 1'b1);
        // largest bitmap
        add_reg(REG_GLYPH_WIDTH, 8'd255);
        add_reg(REG_GLYPH_HEIGHT, 8'd255);
        add_fixed(8'h00, 1'b1, 1, 8'd254, 8'd0, 8'd0, 1'b0);
        add_fixed(8'h80, 1'b0, 1, 8'd254, 8'd1, 8'd128, 1'b0);
        // empty bitmaps
        add_reg(REG_GLYPH_WIDTH, 8'd0);
        add_fixed(8'h55, 1'b1, 0, 8'd0, 8'd0, 8'd0, 1'b0);
        add_reg(REG_GLYPH_WIDTH, 8'd8);
        add_reg(REG_GLYPH_HEIGHT, 8'd0);
        add_fixed(8'hAA, 1'b1, 0, 8'd0, 8'd0, 8'd0, 1'b0);
        // raw 2 bpp and 4 bpp
        add_reg(REG_GLYPH_HEIGHT, 8'd4);
        add_reg(REG_DEPTH_CODE, DEPTH_2BPP);
        add_byte(8'hE4, 1'b1);
        add_byte(8'h1B, 1'b0);
        add_reg(REG_DEPTH_CODE, DEPTH_4BPP);
        add_byte(8'hF0, 1'b1);
        add_byte(8'h0F, 1'b0);
        // run-length at 1 bpp, longest runs
        add_reg(REG_COMPRESSED, 8'd1);
        add_reg(REG_DEPTH_CODE, DEPTH_1BPP);
        add_reg(REG_GLYPH_HEIGHT, 8'd8);
        add_byte(8'h1F, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        // run-length at 8 bpp: an element spans two bytes
        add_reg(REG_DEPTH_CODE, DEPTH_8BPP);
        add_byte(8'h3F, 1'b1);
        add_byte(8'hFF, 1'b0);
        // run that overflows a 2 x 2 bitmap
        add_reg(REG_DEPTH_CODE, DEPTH_2BPP);
        add_reg(REG_GLYPH_WIDTH, 8'd2);
        add_reg(REG_GLYPH_HEIGHT, 8'd2);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        // size shrunk under the scan position
        add_reg(REG_COMPRESSED, 8'd0);
        add_reg(REG_DEPTH_CODE, DEPTH_8BPP);
        add_reg(REG_GLYPH_WIDTH, 8'd8);
        add_reg(REG_GLYPH_HEIGHT, 8'd8);
        add_byte(8'h11, 1'b1);
        add_reg(REG_GLYPH_WIDTH, 8'd1);
        add_byte(8'h22, 1'b0);
        add_reg(REG_GLYPH_HEIGHT, 8'd2);
        add_byte(8'h33, 1'b0);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                settle();
                write_reg(plan[i].index, plan[i].value);
            end else begin
                fixed_on    = plan[i].fixed;
                fixed_count = plan[i].fixed_count;
                fixed_px    = plan[i].fixed_px;
                send_byte(plan[i].value, plan[i].first);
            end
        end
        fixed_on = 1'b0;

        // random part: phases of random settings, mostly whole glyphs
        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            settle();
            no_idle = ($urandom_range(0, 3) == 0);
            pick    = $urandom_range(0, 9);
            if (pick < 6) begin
                w = 8'($urandom_range(1, 6));
                h = 8'($urandom_range(1, 6));
            end else if (pick < 8) begin
                w = 8'($urandom_range(1, 255));
                h = 8'($urandom_range(1, 4));
            end else begin
                w = 8'($urandom_range(1, 4));
                h = 8'($urandom_range(1, 255));
            end
            write_reg(REG_DEPTH_CODE, 8'($urandom_range(0, 3)));
            write_reg(REG_COMPRESSED, 8'($urandom_range(0, 1)));
            write_reg(REG_GLYPH_WIDTH, w);
            write_reg(REG_GLYPH_HEIGHT, h);
            // now and then carry the old scan position into the new size
            first_next = !(phase > 0 && $urandom_range(0, 4) == 0);
            target     = $urandom_range(15, 40);
            in_phase   = 0;
            while (in_phase < target && total < RANDOM_ITEMS) begin
                glyph_bytes = 0;
                do begin
                    counted = first_next || !glyph_full;
                    send_byte(8'($urandom_range(0, 255)), first_next);
                    if (counted) begin
                        total    = total + 1;
                        in_phase = in_phase + 1;
                    end
                    glyph_bytes = glyph_bytes + 1;
                    // occasional restart in mid glyph
                    first_next = ($urandom_range(0, 19) == 0);
                    if ((counted && total == 5) || $urandom_range(0, 39) == 0) settle();
                end while (!glyph_full && glyph_bytes < GLYPH_CAP && in_phase < target);
                // stray bytes after a full bitmap
                if (glyph_full && $urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
                first_next = 1'b1;
            end
            phase = phase + 1;
        end

        in_bus.valid = 1'b0;
        while (pixels_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
